### sv/reb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package reb_pkg;

   localparam int COUNT_WIDTH     = 32;
   localparam int POSITION_WIDTH  = 32;
   localparam int MIN_PRESS_WIDTH = 16;
   localparam int TIME_WIDTH      = 32;
   localparam int CMD_WIDTH       = 2;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = MIN_PRESS_WIDTH;

   localparam int REQ_FIELD_BITS  = 3 + TIME_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS  = POSITION_WIDTH + 1;
   localparam int RSP_TDATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [MIN_PRESS_WIDTH-1:0] MIN_PRESS_RESET = MIN_PRESS_WIDTH'(50);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_SAMPLE      = 2'd0,
      CMD_CLEAR_COUNT = 2'd1,
      CMD_CLEAR_FLAG  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_PRESS_MS   = 1'd0,
      CSR_HALF_RATE_MODE = 1'd1
   } csr_index_type;

endpackage

`default_nettype wire

### sv/rotary_encoder_with_button_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Quadrature decoder for a rotary encoder with a push button. Each request item
// is a pin sample (active-low A, B and button levels with a millisecond
// timestamp), a clear-counter command or a clear-flag command, selected by
// req_tuser. Every item returns one response item holding the signed position
// counter and the qualified-press flag as they stand after that item. The unit
// takes one item per cycle unless stalled; the response appears in the cycle
// after the item is accepted, held in a single output register, and a new item
// is accepted whenever that register is empty or drained in the same cycle.
// Configuration registers should be written only while no item is in flight.
module rotary_encoder_with_button_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: pin_a, pin_b, pin_button, now_ms[31:0], zero fill.
   input  wire  [reb_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // Fields from bit 0: cmd[1:0].
   input  wire  [reb_pkg::CMD_WIDTH-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // Fields from bit 0: position[31:0] (signed), press_flag, zero fill.
   output logic [reb_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input  wire                                   csr_we,
   input  wire  [reb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [reb_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import reb_pkg::*;

   logic [MIN_PRESS_WIDTH-1:0] min_press_ff;
   logic                       half_rate_ff;

   logic                       a_prev_ff,      a_prev_in;
   logic                       phase_ff,       phase_in;
   logic                       button_prev_ff, button_prev_in;
   logic [TIME_WIDTH-1:0]      press_start_ff, press_start_in;
   logic [COUNT_WIDTH-1:0]     count_ff,       count_in;
   logic                       pressed_ff,     pressed_in;

   logic                       rsp_valid_ff,   rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff,    rsp_data_in;

   logic                       accept;
   cmd_type                    cmd;
   logic                       a_act, b_act, btn_act;
   logic [TIME_WIDTH-1:0]      now_ms;
   logic [TIME_WIDTH-1:0]      held;
   logic                       a_change;
   logic [COUNT_WIDTH+POSITION_WIDTH-1:0] count_ext;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cmd     = cmd_type'(req_tuser);
   assign a_act   = ~req_tdata[0];
   assign b_act   = ~req_tdata[1];
   assign btn_act = ~req_tdata[2];
   assign now_ms  = req_tdata[3 +: TIME_WIDTH];
   assign held    = now_ms - press_start_ff;
   assign a_change = a_act != a_prev_ff;

   always_comb begin
      a_prev_in      = a_prev_ff;
      phase_in       = phase_ff;
      button_prev_in = button_prev_ff;
      press_start_in = press_start_ff;
      count_in       = count_ff;
      pressed_in     = pressed_ff;
      case (cmd)
         CMD_SAMPLE: begin
            if (a_change) begin
               phase_in  = ~phase_ff;
               a_prev_in = a_act;
               if (!half_rate_ff || !phase_ff) begin
                  if (b_act != a_prev_ff) begin
                     count_in = count_ff - COUNT_WIDTH'(1);
                  end else begin
                     count_in = count_ff + COUNT_WIDTH'(1);
                  end
               end
            end
            if (btn_act && !button_prev_ff) begin
               press_start_in = now_ms;
               button_prev_in = 1'b1;
            end else if (!btn_act && button_prev_ff) begin
               if (held >= TIME_WIDTH'(min_press_ff)) begin
                  pressed_in = 1'b1;
               end
               button_prev_in = 1'b0;
            end
         end
         CMD_CLEAR_COUNT: begin
            count_in = '0;
         end
         CMD_CLEAR_FLAG: begin
            pressed_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign count_ext = {{POSITION_WIDTH{count_in[COUNT_WIDTH-1]}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[POSITION_WIDTH-1:0] = count_ext[POSITION_WIDTH-1:0];
         rsp_data_in[POSITION_WIDTH]     = pressed_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_press_ff <= MIN_PRESS_RESET;
         half_rate_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_PRESS_MS:   min_press_ff <= csr_wdata;
            CSR_HALF_RATE_MODE: half_rate_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_prev_ff      <= 1'b0;
         phase_ff       <= 1'b0;
         button_prev_ff <= 1'b0;
         press_start_ff <= '0;
         count_ff       <= '0;
         pressed_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            a_prev_ff      <= a_prev_in;
            phase_ff       <= phase_in;
            button_prev_ff <= button_prev_in;
            press_start_ff <= press_start_in;
            count_ff       <= count_in;
            pressed_ff     <= pressed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no response");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_CLEAR_COUNT) |=>
         (count_ff == '0 && rsp_data_ff[POSITION_WIDTH-1:0] == '0))
      else $error("clear-counter command left a nonzero position");

   a_clear_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_CLEAR_FLAG) |=> (!pressed_ff && !rsp_data_ff[POSITION_WIDTH]))
      else $error("clear-flag command left the press flag set");

   a_flag_on_release: assert property (@(posedge clock) disable iff (reset)
      $rose(pressed_ff) |-> ($past(accept) && $past(button_prev_ff) && !button_prev_ff))
      else $error("press flag set without a button release");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
